@@ sv/fbsx_pkg.sv @@
// shared types and constants for the frame builder with sum and xor check
// no dependencies
`default_nettype none

package fbsx_pkg;

  localparam logic [7:0] START_BYTE = 8'hFE;
  localparam logic [7:0] END_BYTE   = 8'hFF;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd7;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // one classified item as it waits for the back end
  typedef struct packed {
    logic       is_start;        // item opens a frame and carries the header
    logic       close;           // item ends the payload, trailer follows
    logic [7:0] frame_type;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
  } entry_t;

  // head-of-queue status seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

`default_nettype wire

@@ sv/fbsx_front.sv @@
// front end: accepts input items and classifies them as frame start or payload
// depends on fbsx_pkg
`default_nettype none

module fbsx_front
  import fbsx_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [31:0]  in_data,
  input  wire logic         q_full,
  output logic              push,
  output entry_t            push_entry
);

  logic       in_frame;
  logic [7:0] bytes_left;
  logic [7:0] in_type, in_cmd, in_len, in_dat;

  assign in_type = in_data[7:0];
  assign in_cmd  = in_data[15:8];
  assign in_len  = in_data[23:16];
  assign in_dat  = in_data[31:24];

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // classify the item against the open frame
  always_comb begin
    push_entry.is_start       = !in_frame;
    push_entry.frame_type     = in_type;
    push_entry.command        = in_cmd;
    push_entry.payload_length = in_len;
    push_entry.data_byte      = in_dat;
    if (!in_frame) begin
      push_entry.close = (in_len == 8'd0) || (in_len == 8'd1);
    end else begin
      push_entry.close = (bytes_left == 8'd1);
    end
  end

  // frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      bytes_left <= 8'd0;
    end else if (push) begin
      if (!in_frame) begin
        in_frame   <= (in_len > 8'd1);
        bytes_left <= (in_len == 8'd0) ? 8'd0 : in_len - 8'd1;
      end else begin
        in_frame   <= (bytes_left != 8'd1);
        bytes_left <= bytes_left - 8'd1;
      end
    end
  end

`ifndef SYNTHESIS
  // an idle front never counts outstanding payload
  assert property (@(posedge clk) disable iff (rst) !in_frame |-> bytes_left == 8'd0)
    else $error("front idle with payload outstanding");
`endif

endmodule

`default_nettype wire

@@ sv/fbsx_queue.sv @@
// short flip-flop queue that decouples the front and back ends
// depends on fbsx_pkg
`default_nettype none

module fbsx_queue
  import fbsx_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  entry_t      push_entry,
  output logic        full,
  input  wire logic   pop,
  output head_t       head
);

  entry_t          slots [QDEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QAW:0]    count;

  assign full       = (count == (QAW+1)'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) count <= (QAW+1)'(QDEPTH))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
                   (!rst && push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

@@ sv/fbsx_back.sv @@
// back end: expands queued items into frame bytes with sum and xor trailer
// depends on fbsx_pkg
`default_nettype none

module fbsx_back
  import fbsx_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  head_t             head,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [23:0]       out_data,
  output logic              out_last
);

  typedef enum logic [2:0] {
    S_START, S_TYPE, S_CMD, S_LEN, S_DATA, S_SUM, S_XOR, S_END
  } step_t;

  step_t      step;
  logic       mid;
  step_t      cur_step;
  step_t      step_next;
  logic       done;
  logic       advance;
  logic [7:0] emit_byte;
  logic       accum;
  logic [7:0] running_sum;
  logic [7:0] running_xor;
  logic [7:0] length_held;
  entry_t     e;

  assign e       = head.entry;
  assign advance = head.valid && (!out_valid || out_ready);
  assign pop     = advance && done;

  // current step, byte to send and the step after it
  always_comb begin
    if (mid) begin
      cur_step = step;
    end else begin
      cur_step = e.is_start ? S_START : S_DATA;
    end
    step_next = cur_step;
    done      = 1'b0;
    accum     = 1'b0;
    emit_byte = END_BYTE;
    case (cur_step)
      S_START: begin
        emit_byte = START_BYTE;
        step_next = S_TYPE;
      end
      S_TYPE: begin
        emit_byte = e.frame_type;
        accum     = 1'b1;
        step_next = S_CMD;
      end
      S_CMD: begin
        emit_byte = e.command;
        accum     = 1'b1;
        step_next = S_LEN;
      end
      S_LEN: begin
        emit_byte = e.payload_length;
        accum     = 1'b1;
        step_next = (e.payload_length == 8'd0) ? S_SUM : S_DATA;
      end
      S_DATA: begin
        emit_byte = e.data_byte;
        accum     = 1'b1;
        step_next = S_SUM;
        done      = !e.close;
      end
      S_SUM: begin
        emit_byte = running_sum;
        step_next = S_XOR;
      end
      S_XOR: begin
        emit_byte = running_xor;
        step_next = S_END;
      end
      S_END: begin
        emit_byte = END_BYTE;
        done      = 1'b1;
      end
      default: begin
        emit_byte = END_BYTE;
        done      = 1'b1;
      end
    endcase
  end

  // sequencer state, check accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mid         <= 1'b0;
      step        <= S_START;
      out_valid   <= 1'b0;
      running_sum <= 8'd0;
      running_xor <= 8'd0;
      length_held <= 8'd0;
    end else begin
      if (advance) begin
        mid       <= !done;
        step      <= step_next;
        out_valid <= 1'b1;
        out_last  <= (cur_step == S_END);
        out_data  <= {7'd0,
                      (cur_step == S_END) ? {1'b0, length_held} + FRAME_OVERHEAD : 9'd0,
                      emit_byte};
        if (cur_step == S_START) begin
          running_sum <= 8'd0;
          running_xor <= 8'd0;
          length_held <= e.payload_length;
        end else if (accum) begin
          running_sum <= running_sum + emit_byte;
          running_xor <= running_xor ^ emit_byte;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // the closing marker only ever rides on the end byte
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && out_last) |-> out_data[7:0] == END_BYTE)
    else $error("frame end on a byte other than the end byte");
  // an item in the middle of expansion stays at the queue head
  assert property (@(posedge clk) disable iff (rst) mid |-> head.valid)
    else $error("queue head lost during expansion");
`endif

endmodule

`default_nettype wire

@@ sv/frame_builder_sum_xor_core.sv @@
// frame builder top: accepted item -> queue -> registered first frame byte on m_tdata
// payload items sustain 1 item per cycle while m_tready holds; a start item first sends
// start, type, command and length bytes, and a closing item adds sum, xor and end bytes
// a 4-entry queue lets the front keep accepting while the back expands headers
// rst is synchronous, active high: idle, queue empty, no output pending
`default_nettype none

module frame_builder_sum_xor_core
  import fbsx_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,   // frame_type, command, payload_length, data_byte
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [23:0]       m_tdata,   // frame_byte [7:0], frame_total [16:8], zero pad
  output logic              m_tlast    // frame_end
);

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   pop;
  head_t  head;

  // item intake and classification
  fbsx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  fbsx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head)
  );

  // frame byte sequencer
  fbsx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire
